>>> rtl/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants of the affine texel sampler: request codes,
// register indexes, reset values, the queued command and the config bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

    // Request kinds carried in tuser[1:0]
    localparam logic [1:0] REQ_WRITE = 2'd0;   // texel store write
    localparam logic [1:0] REQ_FIRST = 2'd1;   // first pixel of a run
    localparam logic [1:0] REQ_NEXT  = 2'd2;   // following pixel
    localparam logic [1:0] REQ_UNUSED = 2'd3;  // dropped

    // Register indexes (byte address 4*i)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TRANS  = 2'd2;

    // Register reset values
    localparam logic [8:0] RST_WIDTH  = 9'd64;
    localparam logic [8:0] RST_HEIGHT = 9'd128;
    localparam logic [7:0] RST_TRANS  = 8'd247;

    // Port widths
    localparam int IN_DATA_W  = 168;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 1;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic {
        K_WRITE,
        K_PIXEL
    } t_kind;

    // One classified request as it travels from front to back
    typedef struct packed {
        t_kind       kind;
        logic        occluded;
        logic [31:0] u;        // column coordinate, signed fixed point
        logic [31:0] v;        // row coordinate, signed fixed point
        logic [15:0] rshift;   // signed integer row offset
        logic [15:0] addr;     // texel write address
        logic [7:0]  data;     // texel write data
    } t_cmd;

    typedef struct packed {
        logic [8:0] width;
        logic [8:0] height;
        logic [7:0] trans;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/ats_front.sv
// ----------------------------------------------------------------------------
// ats_front
// Request front end: unpacks the input stream, keeps the coordinate
// accumulators and steps, and pushes one command per write or pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tvalid,
    output logic                               o_tready,
    // tdata: texel_address[15:0], texel_data[23:16], start_u[55:24],
    //        start_v[87:56], step_u[119:88], step_v[151:120], row_offset[167:152]
    input  wire logic [ats_pkg::IN_DATA_W-1:0] i_tdata,
    // tuser: req_type[1:0], occluded[2]
    input  wire logic [ats_pkg::IN_USER_W-1:0] i_tuser,
    output logic                               o_push_valid,
    output ats_pkg::t_cmd                      o_push_cmd,
    input  wire logic                          i_push_ready
);
    import ats_pkg::*;

    logic [1:0]  req;
    logic [15:0] in_addr;
    logic [7:0]  in_data;
    logic [31:0] start_u, start_v, step_u, step_v;
    logic [15:0] row_off;
    logic        accept;

    logic [31:0] r_acc_u, r_acc_v, r_inc_u, r_inc_v;
    logic [15:0] r_rshift;

    // Field unpack
    assign req     = i_tuser[1:0];
    assign in_addr = i_tdata[15:0];
    assign in_data = i_tdata[23:16];
    assign start_u = i_tdata[55:24];
    assign start_v = i_tdata[87:56];
    assign step_u  = i_tdata[119:88];
    assign step_v  = i_tdata[151:120];
    assign row_off = i_tdata[167:152];

    assign o_tready     = i_push_ready;
    assign accept       = i_tvalid && i_push_ready;
    assign o_push_valid = i_tvalid && (req != REQ_UNUSED);

    // Classify the request into a command
    always_comb begin
        o_push_cmd          = '0;
        o_push_cmd.kind     = K_PIXEL;
        o_push_cmd.occluded = i_tuser[2];
        unique case (req)
            REQ_WRITE: begin
                o_push_cmd.kind = K_WRITE;
                o_push_cmd.addr = in_addr;
                o_push_cmd.data = in_data;
            end
            REQ_FIRST: begin
                o_push_cmd.u      = start_u;
                o_push_cmd.v      = start_v;
                o_push_cmd.rshift = row_off;
            end
            REQ_NEXT: begin
                o_push_cmd.u      = r_acc_u;
                o_push_cmd.v      = r_acc_v;
                o_push_cmd.rshift = r_rshift;
            end
            default: begin
                o_push_cmd.kind = K_WRITE;
            end
        endcase
    end

    // Accumulators advance once per accepted pixel, wrapping mod 2^32
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_u  <= '0;
            r_acc_v  <= '0;
            r_inc_u  <= '0;
            r_inc_v  <= '0;
            r_rshift <= '0;
        end else if (accept) begin
            unique case (req)
                REQ_FIRST: begin
                    r_acc_u  <= start_u + step_u;
                    r_acc_v  <= start_v + step_v;
                    r_inc_u  <= step_u;
                    r_inc_v  <= step_v;
                    r_rshift <= row_off;
                end
                REQ_NEXT: begin
                    r_acc_u <= r_acc_u + r_inc_u;
                    r_acc_v <= r_acc_v + r_inc_v;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/ats_queue.sv
// ----------------------------------------------------------------------------
// ats_queue
// Two-entry command queue between front end and sampling back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    input  wire ats_pkg::t_cmd i_push_cmd,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output ats_pkg::t_cmd      o_pop_cmd,
    input  wire logic          i_pop_ready
);
    import ats_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_slot[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/ats_back.sv
// ----------------------------------------------------------------------------
// ats_back
// Sampling back end: texel store, bit-serial wrap of column and row into
// the texture size, address build, store read and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_back #(
    parameter int STORE_DEPTH = 65536,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_pop_valid,
    input  wire ats_pkg::t_cmd i_cmd,
    output logic               o_pop_ready,
    input  wire ats_pkg::t_cfg i_cfg,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [7:0]         o_index,
    output logic               o_masked
);
    import ats_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int TI_W   = 32 - FRAC_BITS;          // integer magnitude bits
    localparam int SUM_W  = ((33 - FRAC_BITS) > 17 ? (33 - FRAC_BITS) : 17) + 1;
    localparam int CNT_W  = $clog2(SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_FIX,
        S_ADDR,
        S_READ,
        S_DONE
    } t_state;

    // Size 0 acts as 1, above 256 acts as 256
    function automatic logic [8:0] clamp_size(input logic [8:0] s);
        if (s == 9'd0) begin
            return 9'd1;
        end else if (s > 9'd256) begin
            return 9'd256;
        end
        return s;
    endfunction

    // One restoring remainder step
    function automatic logic [8:0] rem_step(input logic [8:0] rem, input logic b,
                                            input logic [8:0] d);
        logic [9:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[8:0];
    endfunction

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [8:0]         r_w, r_h;
    logic [7:0]         r_trans;
    logic               r_masked;
    logic               r_uneg, r_vneg, r_rneg;
    logic [TI_W-1:0]    r_umag, r_vmag;
    logic [15:0]        r_rs;
    logic [SUM_W-1:0]   r_cdiv, r_rdiv;
    logic [8:0]         r_crem, r_rrem;
    logic [7:0]         r_col, r_row;
    logic [ADDR_W-1:0]  r_addr;
    logic [7:0]         r_rd;
    logic               r_ovalid;
    logic [7:0]         r_oindex;
    logic               r_omasked;

    logic [7:0]         mem [STORE_DEPTH];

    logic [31:0]        u_abs, v_abs;
    logic [SUM_W-1:0]   v_ext, v_sgn, rs_ext, row_sum, row_mag;
    logic [8:0]         col_fix, row_fix;
    logic [16:0]        lin_addr;
    logic [ADDR_W+15:0] rd_ext, wr_ext;
    logic               mem_we;

    assign o_pop_ready = (r_state == S_IDLE);
    assign o_tvalid    = r_ovalid;
    assign o_index     = r_oindex;
    assign o_masked    = r_omasked;

    // Coordinate magnitudes, truncated toward zero
    assign u_abs = i_cmd.u[31] ? (~i_cmd.u + 32'd1) : i_cmd.u;
    assign v_abs = i_cmd.v[31] ? (~i_cmd.v + 32'd1) : i_cmd.v;

    // Row plus offset, then its magnitude
    assign v_ext   = {{(SUM_W - TI_W){1'b0}}, r_vmag};
    assign v_sgn   = r_vneg ? (~v_ext + SUM_W'(1)) : v_ext;
    assign rs_ext  = {{(SUM_W - 16){r_rs[15]}}, r_rs};
    assign row_sum = v_sgn + rs_ext;
    assign row_mag = row_sum[SUM_W-1] ? (~row_sum + SUM_W'(1)) : row_sum;

    // True modulo for negative values
    assign col_fix = (r_uneg && r_crem != 9'd0) ? (r_w - r_crem) : r_crem;
    assign row_fix = (r_rneg && r_rrem != 9'd0) ? (r_h - r_rrem) : r_rrem;

    // row * width + column, folded into the store
    assign lin_addr = ({9'd0, r_row} * {8'd0, r_w}) + {9'd0, r_col};
    assign rd_ext   = {{ADDR_W{1'b0}}, lin_addr[15:0]};
    assign wr_ext   = {{ADDR_W{1'b0}}, i_cmd.addr};

    assign mem_we = (r_state == S_IDLE) && i_pop_valid && (i_cmd.kind == K_WRITE);

    // Texel store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_ext[ADDR_W-1:0]] <= i_cmd.data;
        end
        r_rd <= mem[r_addr];
    end

    // Sequencer, datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // Drain the result register; S_DONE refills it itself
            if (r_ovalid && i_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid && i_cmd.kind == K_PIXEL) begin
                        r_w      <= clamp_size(i_cfg.width);
                        r_h      <= clamp_size(i_cfg.height);
                        r_trans  <= i_cfg.trans;
                        r_masked <= i_cmd.occluded;
                        r_uneg   <= i_cmd.u[31];
                        r_vneg   <= i_cmd.v[31];
                        r_umag   <= u_abs[31:FRAC_BITS];
                        r_vmag   <= v_abs[31:FRAC_BITS];
                        r_rs     <= i_cmd.rshift;
                        r_state  <= i_cmd.occluded ? S_DONE : S_SUM;
                    end
                end
                S_SUM: begin
                    r_cdiv  <= {{(SUM_W - TI_W){1'b0}}, r_umag};
                    r_rdiv  <= row_mag;
                    r_rneg  <= row_sum[SUM_W-1];
                    r_crem  <= 9'd0;
                    r_rrem  <= 9'd0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_crem <= rem_step(r_crem, r_cdiv[SUM_W-1], r_w);
                    r_rrem <= rem_step(r_rrem, r_rdiv[SUM_W-1], r_h);
                    r_cdiv <= r_cdiv << 1;
                    r_rdiv <= r_rdiv << 1;
                    r_cnt  <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SUM_W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_col   <= col_fix[7:0];
                    r_row   <= row_fix[7:0];
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_addr  <= rd_ext[ADDR_W-1:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || i_tready) begin
                        r_ovalid  <= 1'b1;
                        r_oindex  <= r_masked ? r_trans : r_rd;
                        r_omasked <= r_masked;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_crem < r_w && r_rrem < r_h))
        else $error("partial remainder not below texture size");

    a_coord_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |-> ({1'b0, r_col} < r_w && {1'b0, r_row} < r_h))
        else $error("wrapped texel coordinate outside texture");

endmodule

`default_nettype wire

>>> rtl/affine_texel_sampler.sv
// ----------------------------------------------------------------------------
// affine_texel_sampler
// Texel sampler for affine-mapped wall columns, sprite columns and floor
// spans, with a texel store, an APB register port and stream in/out.
// ----------------------------------------------------------------------------
// The front end takes one request per cycle while its two-entry command
// queue has room, so writes and pixels stream in independently of the
// sampler. In the back end a texel write is stored as it leaves the queue,
// an occluded pixel goes straight to the result register, and a sampled
// pixel has column and row wrapped into the texture size by a bit-serial
// remainder over a SUM_W-bit dividend, SUM_W = max(33 - FRAC_BITS, 17) + 1,
// that retires one dividend bit per cycle, followed by the address
// multiply and the registered store read. A finished result waits in the
// output register while the next command is taken. STORE_DEPTH must be a
// power of two; texel entries are undefined until written.
`default_nettype none

module affine_texel_sampler #(
    parameter int STORE_DEPTH = 65536,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: texel_address[15:0], texel_data[23:16], start_u[55:24],
    //        start_v[87:56], step_u[119:88], step_v[151:120], row_offset[167:152]
    input  wire logic [ats_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: req_type[1:0], occluded[2]
    input  wire logic [ats_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata: pixel_index[7:0]
    output logic [ats_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: pixel_masked[0]
    output logic [ats_pkg::OUT_USER_W-1:0]      o_m_axis_tuser,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ats_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [ats_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ats_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import ats_pkg::*;

    logic       push_valid, push_ready, pop_valid, pop_ready;
    t_cmd       push_cmd, pop_cmd;
    t_cfg       r_cfg;
    logic [1:0] reg_idx;
    logic       cfg_we;
    logic [7:0] out_index;
    logic       out_masked;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.trans  <= RST_TRANS;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_WIDTH:  r_cfg.width  <= pwdata[8:0];
                REG_HEIGHT: r_cfg.height <= pwdata[8:0];
                REG_TRANS:  r_cfg.trans  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = {23'd0, r_cfg.width};
            REG_HEIGHT: prdata = {23'd0, r_cfg.height};
            REG_TRANS:  prdata = {24'd0, r_cfg.trans};
            default:    prdata = '0;
        endcase
    end

    ats_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (i_s_axis_tvalid),
        .o_tready     (o_s_axis_tready),
        .i_tdata      (i_s_axis_tdata),
        .i_tuser      (i_s_axis_tuser),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    ats_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    ats_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_pop_ready (pop_ready),
        .i_cfg       (r_cfg),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_index     (out_index),
        .o_masked    (out_masked)
    );

    assign o_m_axis_tdata = out_index;
    assign o_m_axis_tuser = out_masked;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for affine_texel_sampler. A short table of directed
// requests, then random texel writes and pixel runs under several register
// settings, with random stalls on both streams. Every returned pixel is
// compared against a built-in model of the sampler or a directed row's pixel.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ats_pkg::*;

    localparam int STORE_DEPTH    = 65536;
    localparam int FRAC_BITS      = 16;
    localparam int SETTLE_CYCLES  = 64;   // well past the longest back-end pass
    localparam int PHASES         = 10;
    localparam int PHASE_REQUESTS = 100;

    // One input request, fields at the block's widths
    typedef struct packed {
        logic [1:0]  kind;
        logic        occluded;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [31:0] start_u;
        logic [31:0] start_v;
        logic [31:0] step_u;
        logic [31:0] step_v;
        logic [15:0] row_offset;
    } t_texel_req;

    typedef struct packed {
        logic [7:0] index;
        logic       masked;
    } t_pixel;

    typedef struct packed {
        t_texel_req req;
        logic       known;   // pixel below is the expected one
        t_pixel     pixel;
    } t_directed_row;

    // Directed requests: after-reset state, field extremes, negative coords
    localparam t_directed_row DIRECTED_ROWS [20] = '{
        // following pixel before any first pixel, occluded
        '{'{REQ_NEXT, 1'b1, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b1, '{RST_TRANS, 1'b1}},
        '{'{REQ_WRITE, 1'b0, 16'h0000, 8'hA5, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        // reset accumulators sample texel zero
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b1, '{8'hA5, 1'b0}},
        '{'{REQ_WRITE, 1'b0, 16'hFFFF, 8'hFF, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        // unused kind, all ones, must leave no trace
        '{'{REQ_UNUSED, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '{8'h00, 1'b0}},
        '{'{REQ_FIRST, 1'b0, 16'h0000, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF}, 1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b1, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b1, '{RST_TRANS, 1'b1}},
        '{'{REQ_FIRST, 1'b0, 16'h0000, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 16'h8000}, 1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        // just below zero: truncation toward zero, true modulo wrap
        '{'{REQ_FIRST, 1'b0, 16'h0000, 8'h00, 32'hFFFF_0001, 32'hFFFE_FFFF,
            32'hFFFF_FFFF, 32'h0001_0000, 16'hFFFF}, 1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        // occluded first pixel still loads zero start and steps
        '{'{REQ_FIRST, 1'b1, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b1, '{RST_TRANS, 1'b1}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b1, '{8'hA5, 1'b0}},
        // coordinates exactly one texture size out
        '{'{REQ_FIRST, 1'b0, 16'h0000, 8'h00, 32'h0040_0000, 32'h0080_0000,
            32'h0001_0000, 32'hFFFF_0000, 16'h0000}, 1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        '{'{REQ_FIRST, 1'b0, 16'h0000, 8'h00, 32'h0003_FFFF, 32'hFFFC_0001,
            32'h0000_8000, 32'hFFFF_8000, 16'h0080}, 1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}},
        '{'{REQ_NEXT, 1'b0, 16'h0000, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0},
          1'b0, '{8'h00, 1'b0}}
    };

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [IN_USER_W-1:0]  s_user  = '0;
    logic                  m_ready = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    wire                   s_ready;
    wire                   m_valid;
    wire [OUT_DATA_W-1:0]  m_data;
    wire [OUT_USER_W-1:0]  m_user;
    wire [CFG_DATA_W-1:0]  prdata;
    wire                   pready;

    // Sampler model state
    logic [7:0]  texel_mem   [STORE_DEPTH];
    bit          texel_valid [STORE_DEPTH];
    logic [31:0] u_acc, v_acc, u_step, v_step;
    logic [15:0] row_off;
    logic [8:0]  tex_w, tex_h;
    logic [7:0]  trans_idx;

    t_pixel pending_pixels [$];
    int     errors         = 0;
    int     requests_sent  = 0;
    int     pixels_checked = 0;
    int     stall_left     = 0;
    logic   quiet          = 1'b0;

    affine_texel_sampler #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int clamp_size(logic [8:0] s);
        if (s == 9'd0) return 1;
        if (s > 9'd256) return 256;
        return int'(s);
    endfunction

    // Integer part of a fixed-point coordinate, truncated toward zero
    function automatic int texel_coord(logic [31:0] acc);
        longint s;
        s = longint'($signed(acc));
        return int'(s / (longint'(1) << FRAC_BITS));
    endfunction

    function automatic int wrap_into(int v, int n);
        int r;
        r = v % n;
        return (r < 0) ? r + n : r;
    endfunction

    // Store entry the request would sample, -1 if it reads nothing
    function automatic int sampled_entry(t_texel_req r);
        logic [31:0] u, v;
        logic [15:0] ro;
        int          w, h, col, row;
        if (r.occluded || (r.kind != REQ_FIRST && r.kind != REQ_NEXT)) return -1;
        u   = (r.kind == REQ_FIRST) ? r.start_u : u_acc;
        v   = (r.kind == REQ_FIRST) ? r.start_v : v_acc;
        ro  = (r.kind == REQ_FIRST) ? r.row_offset : row_off;
        w   = clamp_size(tex_w);
        h   = clamp_size(tex_h);
        col = wrap_into(texel_coord(u), w);
        row = wrap_into(texel_coord(v) + int'($signed(ro)), h);
        return (row * w + col) % STORE_DEPTH;
    endfunction

    // Advance the model by one accepted request; returns 1 if a pixel is due
    function automatic bit predict_pixel(t_texel_req r, output t_pixel px);
        int entry;
        px = '0;
        if (r.kind == REQ_WRITE) begin
            texel_mem[r.addr]   = r.data;
            texel_valid[r.addr] = 1'b1;
            return 1'b0;
        end
        if (r.kind == REQ_UNUSED) return 1'b0;
        entry = sampled_entry(r);
        if (r.kind == REQ_FIRST) begin
            u_acc   = r.start_u;
            v_acc   = r.start_v;
            u_step  = r.step_u;
            v_step  = r.step_v;
            row_off = r.row_offset;
        end
        if (r.occluded) px = '{trans_idx, 1'b1};
        else px = '{texel_mem[entry], 1'b0};
        u_acc += u_step;
        v_acc += v_step;
        return 1'b1;
    endfunction

    function automatic t_texel_req random_fields();
        t_texel_req r;
        r.kind       = 2'($urandom_range(0, 3));
        r.occluded   = 1'($urandom_range(0, 1));
        r.addr       = 16'($urandom);
        r.data       = 8'($urandom);
        r.start_u    = $urandom;
        r.start_v    = $urandom;
        r.step_u     = $urandom;
        r.step_v     = $urandom;
        r.row_offset = 16'($urandom);
        return r;
    endfunction

    // First pixel: mostly moderate coordinates and small steps
    function automatic t_texel_req random_run_start();
        t_texel_req r;
        r          = random_fields();
        r.kind     = REQ_FIRST;
        r.occluded = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) != 0) begin
            r.start_u = 32'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
            r.start_v = 32'($urandom_range(0, 32'h03FF_FFFF)) - 32'h0200_0000;
        end
        case ($urandom_range(0, 3))
            0: ;  // full-range steps
            1: begin
                r.step_u = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
                r.step_v = 32'h0;
            end
            default: begin
                r.step_u = 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
                r.step_v = 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
            end
        endcase
        if ($urandom_range(0, 2) != 0)
            r.row_offset = 16'($urandom_range(0, 600)) - 16'd300;
        return r;
    endfunction

    function automatic t_texel_req next_pixel();
        t_texel_req r;
        r          = random_fields();
        r.kind     = REQ_NEXT;
        r.occluded = ($urandom_range(0, 7) == 0);
        return r;
    endfunction

    // Drive one request until accepted, then log its expected pixel
    task automatic push_request(t_texel_req r, bit known, t_pixel known_px);
        t_pixel px;
        t_pixel due;
        s_valid <= 1'b1;
        s_data  <= {r.row_offset, r.step_v, r.step_u, r.start_v, r.start_u, r.data, r.addr};
        s_user  <= {r.occluded, r.kind};
        do @(posedge i_clk); while (!s_ready);
        if (predict_pixel(r, px)) begin
            due            = known ? known_px : px;
            pending_pixels = {pending_pixels, due};
        end
        if (r.kind != REQ_UNUSED) requests_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // A sampled texel that was never written gets a write request first
    task automatic issue_request(t_texel_req r, bit known = 1'b0, t_pixel known_px = '0);
        t_texel_req fill;
        int         entry;
        entry = sampled_entry(r);
        if (entry >= 0 && !texel_valid[entry]) begin
            fill      = random_fields();
            fill.kind = REQ_WRITE;
            fill.addr = 16'(entry);
            push_request(fill, 1'b0, '0);
        end
        push_request(r, known, known_px);
    endtask

    task automatic write_register(logic [1:0] idx, logic [8:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  tex_w = value;
            REG_HEIGHT: tex_h = value;
            default:    trans_idx = value[7:0];
        endcase
        @(posedge i_clk);
    endtask

    // Stop sending, let every pixel return and the back end go quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [8:0] w, logic [8:0] h, logic [7:0] t);
        wait_idle();
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        write_register(REG_TRANS, {1'b0, t});
    endtask

    // Mostly well-formed runs, some stray writes, strays and unused kinds
    task automatic random_traffic(int quota);
        int first_count;
        first_count = requests_sent;
        while (requests_sent - first_count < quota) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    t_texel_req w;
                    w      = random_fields();
                    w.kind = REQ_WRITE;
                    issue_request(w);
                end
                2: begin
                    t_texel_req u;
                    u      = random_fields();
                    u.kind = REQ_UNUSED;
                    issue_request(u);
                end
                3: issue_request(next_pixel());
                default: begin
                    issue_request(random_run_start());
                    repeat ($urandom_range(0, 15)) issue_request(next_pixel());
                end
            endcase
        end
    endtask

    // Output side: random stall bursts until the quiet stretch
    always @(posedge i_clk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_ready    <= 1'b1;
            stall_left <= $urandom_range(0, 19);
        end
    end

    // Compare each returned pixel with the oldest expected one
    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel: pixel_index %0d pixel_masked %0d", m_data, m_user[0]);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_data !== want.index) begin
                    $error("pixel_index: expected %0d, got %0d", want.index, m_data);
                    errors++;
                end
                if (m_user[0] !== want.masked) begin
                    $error("pixel_masked: expected %0d, got %0d", want.masked, m_user[0]);
                    errors++;
                end
                pixels_checked++;
            end
        end
    end

    initial begin : stimulus
        u_acc     = '0;
        v_acc     = '0;
        u_step    = '0;
        v_step    = '0;
        row_off   = '0;
        tex_w     = RST_WIDTH;
        tex_h     = RST_HEIGHT;
        trans_idx = RST_TRANS;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i])
            issue_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].pixel);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;  // reset values
                1: apply_setting(9'd0, 9'd0, 8'd0);
                2: apply_setting(9'd511, 9'd0, 8'd255);
                3: apply_setting(9'd0, 9'd511, 8'h5A);
                4: apply_setting(9'd256, 9'd256, 8'd1);
                5: apply_setting(9'd1, 9'd1, 8'h80);
                6: apply_setting(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)),
                                 8'($urandom));
                7: apply_setting(9'd256, 9'd1, 8'($urandom));
                8: apply_setting(9'($urandom), 9'($urandom), 8'($urandom));
                default: apply_setting(9'd3, 9'd5, 8'($urandom));
            endcase
            if (phase == PHASES - 1) quiet <= 1'b1;
            random_traffic(PHASE_REQUESTS);
        end
        wait_idle();

        $display("Sent %0d requests, checked %0d pixels over %0d register settings",
                 requests_sent, pixels_checked, PHASES);
        $display("(zero and oversize texture sizes, negative coordinates, occlusion)");
        if (errors == 0 && pending_pixels.size() == 0)
            $display("affine_texel_sampler: match");
        else
            $display("affine_texel_sampler: mismatch");
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("affine_texel_sampler: mismatch");
        $finish;
    end

endmodule
